/* hw/rtl/deadline_sorted_entry_pool_top_macros.svh */
// Assertion macros for the deadline ordered entry pool.
// Used by deadline_sorted_entry_pool_top only.
`ifndef DEADLINE_SORTED_ENTRY_POOL_TOP_MACROS_SVH
`define DEADLINE_SORTED_ENTRY_POOL_TOP_MACROS_SVH
// implication checked every clock edge outside reset
`define DSEP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define DSEP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* hw/rtl/dsep_pkg.sv */
// Package for the deadline ordered entry pool: sizes, link codes, word types.
// No dependencies.
package dsep_pkg;
  localparam int PoolSize = 256;
  localparam int LinkW = $clog2(PoolSize + 1);
  localparam int SlotW = $clog2(PoolSize);
  localparam logic [LinkW-1:0] Nil = LinkW'(PoolSize);
  localparam int TimeW = 31;

  typedef logic [LinkW-1:0] link_t;
  typedef logic [SlotW-1:0] slot_t;
  typedef logic [TimeW-1:0] time_t;

  localparam logic ModeInsert = 1'b0;
  localparam logic ModeTick = 1'b1;

  typedef struct packed {
    logic  mode;
    time_t end_time;
    time_t now;
  } in_word_t;

  typedef struct packed {
    logic [7:0] slot;
    logic       evicted;
    logic [7:0] expired_count;
    logic [7:0] active_count;
  } out_word_t;

  function automatic logic [7:0] sat8(input link_t v);
    sat8 = (v > link_t'(255)) ? 8'hFF : v[7:0];
  endfunction
endpackage

/* hw/rtl/deadline_sorted_entry_pool_top.sv */
// Top level of the deadline ordered entry pool: sequencer and link memories.
// Depends on dsep_pkg and deadline_sorted_entry_pool_top_macros.svh.
//
// Usage: one input word per item on in_valid/in_ready, one result word per
// item on out_valid/out_ready. mode 0 inserts end_time into a list sorted by
// deadline, evicting the earliest entry when all PoolSize-1 slots are in use;
// mode 1 releases every head entry with end_time <= now.
// Each item runs under a sequencer around one link memory port and one time
// comparator. An insert goes into an empty list, at the head, at the tail or,
// walking back from the tail, in the middle; when the pool is full it first
// evicts the head. A tick releases head entries one by one until the head
// survives or the list is empty. in_ready is high only when the block is
// idle and the output register is empty, so no item is taken while the last
// one is still in progress.
// After reset a clearing pass writes the free chain into nx_mem and Nil into
// pv_mem, one slot per cycle, with in_ready low. The result register holds
// its word while out_ready is low; the next item waits until it is taken.
`include "deadline_sorted_entry_pool_top_macros.svh"
module deadline_sorted_entry_pool_top
  import dsep_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);
  typedef enum logic [4:0] {
    S_CLR, S_IDLE,
    S_I_POP, S_I_POPW, S_I_EVW, S_I_EVW2, S_I_PLACE, S_I_HDW, S_I_HDW2,
    S_I_TLW, S_I_TLW2, S_I_TLRD, S_I_SCAN, S_I_SCANW, S_I_MIDN, S_I_MIDW, S_I_MIDW2,
    S_I_MIDW3, S_T_HEAD, S_T_HEADW, S_T_NXT, S_T_NXTW, S_DONE
  } state_t;

  state_t state_r;
  time_t  dl_mem [PoolSize];
  link_t  nx_mem [PoolSize];
  link_t  pv_mem [PoolSize];

  link_t  free_top_r, head_r, tail_r, live_r, mp_r, scan_r, nn_r, cnt_r;
  link_t  addr_r;
  time_t  e_r, now_r, rd_dl_r;
  link_t  rd_nx_r, rd_pv_r;
  logic   ev_r, mode_r;
  logic   out_valid_r;
  out_word_t out_r;

  // single memory access port, driven by the sequencer
  logic   nx_we, pv_we, dl_we;
  link_t  nx_wd, pv_wd;
  slot_t  wa, ra;

  assign in_ready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (dl_we) dl_mem[wa] <= e_r;
    if (nx_we) nx_mem[wa] <= nx_wd;
    if (pv_we) pv_mem[wa] <= pv_wd;
    rd_dl_r <= dl_mem[ra];
    rd_nx_r <= nx_mem[ra];
    rd_pv_r <= pv_mem[ra];
  end

  function automatic slot_t sa(input link_t l);
    sa = l[SlotW-1:0];
  endfunction

  always_comb begin
    nx_we = 1'b0; pv_we = 1'b0; dl_we = 1'b0;
    nx_wd = Nil;  pv_wd = Nil;
    wa = sa(mp_r); ra = sa(addr_r);
    case (state_r)
      S_CLR: begin
        nx_we = 1'b1; pv_we = 1'b1; wa = sa(addr_r);
        nx_wd = (addr_r + link_t'(2) < link_t'(PoolSize)) ? addr_r + link_t'(1) : Nil;
      end
      S_I_EVW: begin
        pv_we = (rd_nx_r != Nil); wa = sa(rd_nx_r);
      end
      S_I_EVW2, S_I_POPW: begin
        nx_we = 1'b1; pv_we = 1'b1; dl_we = 1'b1;
      end
      S_I_HDW: begin
        nx_we = 1'b1; nx_wd = head_r; pv_we = 1'b0;
      end
      S_I_HDW2: begin
        pv_we = 1'b1; pv_wd = mp_r; wa = sa(head_r);
      end
      S_I_TLW: begin
        pv_we = 1'b1; pv_wd = tail_r;
      end
      S_I_TLW2: begin
        nx_we = 1'b1; nx_wd = mp_r; wa = sa(tail_r);
      end
      S_I_MIDW: begin
        nx_we = 1'b1; nx_wd = nn_r; pv_we = 1'b1; pv_wd = scan_r;
      end
      S_I_MIDW2: begin
        pv_we = 1'b1; pv_wd = mp_r; wa = sa(nn_r);
      end
      S_I_MIDW3: begin
        nx_we = 1'b1; nx_wd = mp_r; wa = sa(scan_r);
      end
      S_T_HEADW: begin
        nx_we = !(now_r < rd_dl_r); nx_wd = free_top_r; wa = sa(head_r);
      end
      S_T_NXTW: begin
        pv_we = 1'b1; pv_wd = Nil; wa = sa(head_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      addr_r <= '0;
      free_top_r <= '0;
      head_r <= Nil;
      tail_r <= Nil;
      live_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (state_r)
        S_CLR: begin
          addr_r <= addr_r + link_t'(1);
          if (addr_r == link_t'(PoolSize - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid && in_ready) begin
            mode_r <= in_data.mode;
            e_r <= in_data.end_time;
            now_r <= in_data.now;
            ev_r <= (in_data.mode == ModeInsert) && (free_top_r == Nil);
            cnt_r <= '0;
            if (in_data.mode == ModeInsert) begin
              if (free_top_r == Nil) begin
                mp_r <= head_r; addr_r <= head_r;
              end else begin
                mp_r <= free_top_r; addr_r <= free_top_r;
              end
              state_r <= S_I_POP;
            end else begin
              addr_r <= head_r;
              state_r <= (head_r == Nil) ? S_DONE : S_T_HEAD;
            end
          end
        end
        S_I_POP: begin
          if (!ev_r) addr_r <= head_r;
          state_r <= ev_r ? S_I_EVW : S_I_POPW;
        end
        S_I_POPW: begin
          free_top_r <= rd_nx_r;
          live_r <= live_r + link_t'(1);
          addr_r <= head_r;
          state_r <= S_I_PLACE;
        end
        S_I_EVW: begin
          head_r <= rd_nx_r;
          if (tail_r == rd_nx_r) tail_r <= Nil;
          addr_r <= rd_nx_r;
          state_r <= S_I_EVW2;
        end
        S_I_EVW2: begin
          addr_r <= head_r;
          state_r <= S_I_PLACE;
        end
        S_I_PLACE: begin
          // rd_dl_r holds deadline of head (read issued last cycle)
          if (head_r == Nil) begin
            head_r <= mp_r; tail_r <= Nil; state_r <= S_DONE;
          end else if (tail_r == Nil) begin
            if (rd_dl_r < e_r) begin
              state_r <= S_I_TLW;
              tail_r <= head_r;
            end else begin
              tail_r <= head_r; state_r <= S_I_HDW;
            end
          end else if (rd_dl_r >= e_r) begin
            state_r <= S_I_HDW;
          end else begin
            addr_r <= tail_r;
            state_r <= S_I_TLRD;
          end
        end
        S_I_HDW: state_r <= S_I_HDW2;
        S_I_HDW2: begin
          head_r <= mp_r; state_r <= S_DONE;
        end
        S_I_TLW: state_r <= S_I_TLW2;
        S_I_TLW2: begin
          tail_r <= mp_r; state_r <= S_DONE;
        end
        S_I_TLRD: state_r <= S_I_SCANW;
        S_I_SCANW: begin
          // tail deadline now in rd_dl_r, prev in rd_pv_r
          if (rd_dl_r <= e_r) begin
            state_r <= S_I_TLW;
          end else begin
            scan_r <= rd_pv_r; addr_r <= rd_pv_r; state_r <= S_I_SCAN;
          end
        end
        S_I_SCAN: state_r <= S_I_MIDN;
        S_I_MIDN: begin
          if (scan_r == Nil) begin
            scan_r <= head_r; addr_r <= head_r; state_r <= S_I_SCAN;
          end else if (rd_dl_r > e_r && scan_r != head_r) begin
            scan_r <= rd_pv_r; addr_r <= rd_pv_r; state_r <= S_I_SCAN;
          end else begin
            nn_r <= rd_nx_r; state_r <= S_I_MIDW;
          end
        end
        S_I_MIDW: state_r <= S_I_MIDW2;
        S_I_MIDW2: state_r <= S_I_MIDW3;
        S_I_MIDW3: state_r <= S_DONE;
        S_T_HEAD: state_r <= S_T_HEADW;
        S_T_HEADW: begin
          if (now_r < rd_dl_r) begin
            // head survives; undo nothing (write skipped above)
            state_r <= S_DONE;
          end else begin
            free_top_r <= head_r;
            head_r <= rd_nx_r;
            cnt_r <= cnt_r + link_t'(1);
            live_r <= live_r - link_t'(1);
            addr_r <= rd_nx_r;
            if (rd_nx_r == Nil) begin
              tail_r <= Nil; state_r <= S_DONE;
            end else state_r <= S_T_NXT;
          end
        end
        S_T_NXT: state_r <= S_T_NXTW;
        S_T_NXTW: begin
          if (rd_nx_r == Nil) tail_r <= Nil;
          state_r <= S_T_HEAD;
        end
        S_DONE: begin
          out_valid_r <= 1'b1;
          out_r.slot <= (mode_r == ModeTick) ? 8'd0 : 8'(mp_r);
          out_r.evicted <= ev_r;
          out_r.expired_count <= sat8(cnt_r);
          out_r.active_count <= sat8(live_r);
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `DSEP_ASSERT_IMP(a_no_accept_busy, in_valid && in_ready, !out_valid, "accept with result pending")
  `DSEP_ASSERT_NXT(a_done_out, state_r == S_DONE, out_valid, "result not presented")
  `DSEP_ASSERT_IMP(a_live_range, state_r == S_IDLE, live_r < link_t'(PoolSize), "live count overflow")
endmodule
